// ===== sv/slt_pkg.sv =====
// Shared types and constants for the sorted list table.
package slt_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int INDEX_W      = 10;
   localparam int COUNT_W      = 11;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_REMOVE,
      S_READ
   } state_type;

endpackage

// ===== sv/sorted_list_table.sv =====
// Sorted list table: ascending signed values in one synchronous RAM.
//
//   channel   ports                                     handshake
//   command   req_command, req_value, req_index         start & !busy
//   result    rsp_status, rsp_data, rsp_count           rsp_valid, one cycle
//
// Every command gives one result beat, registered in the cycle after the command finishes.
// Insert walks down from the top, one entry per cycle (read, compare, write
// one up), then writes the value; into an empty table it writes at once.
// Remove walks up from the index, one entry per cycle; the last entry needs none.
// Read waits on one RAM read; refused commands finish at once.
// The registered RAM read port sets the one-entry-per-cycle pace.
// Synchronous reset clears fill and control only; no clearing pass.
// The result side has no stall; busy holds off commands while one works.
module sorted_list_table
   import slt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [INDEX_W-1:0]        req_index,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic signed [VALUE_W-1:0] rsp_data,
   output logic [COUNT_W-1:0]        rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int FW = $clog2(CAPACITY + 1);
   localparam int PW = FW + 1;

   logic [VALUE_W-1:0] entries_ff [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   state_type state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [FW-1:0] fill_ff, fill_in;

   logic rsp_valid_ff;
   status_type rsp_status_ff, status_in;
   logic [VALUE_W-1:0] rsp_data_ff, data_in;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic done;
   logic we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [COUNT_W-1:0] idx_ext, fill_ext;
   logic [PW-1:0] ptr_plus2;

   assign idx_ext   = COUNT_W'(req_index);
   assign fill_ext  = COUNT_W'(fill_ff);
   assign ptr_plus2 = PW'(ptr_ff) + PW'(2);

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      value_in  = value_ff;
      fill_in   = fill_ff;
      we        = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;
      done      = 1'b0;
      status_in = ST_OK;
      data_in   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in = req_value;
               unique case (req_command)
                  CMD_INSERT: begin
                     if (fill_ff == FW'(CAPACITY)) begin
                        status_in = ST_FULL;
                        done      = 1'b1;
                     end else if (fill_ff == '0) begin
                        we      = 1'b1;
                        wr_addr = '0;
                        wr_data = req_value;
                        fill_in = fill_ff + FW'(1);
                        done    = 1'b1;
                     end else begin
                        ptr_in   = AW'(fill_ff);
                        rd_addr  = AW'(fill_ff - FW'(1));
                        state_in = S_INSERT;
                     end
                  end
                  CMD_REMOVE: begin
                     if (fill_ff == '0) begin
                        status_in = ST_EMPTY;
                        done      = 1'b1;
                     end else if (idx_ext >= fill_ext) begin
                        status_in = ST_RANGE;
                        done      = 1'b1;
                     end else if (idx_ext + COUNT_W'(1) == fill_ext) begin
                        // last entry: nothing to shift
                        fill_in = fill_ff - FW'(1);
                        done    = 1'b1;
                     end else begin
                        ptr_in   = AW'(req_index);
                        rd_addr  = AW'(idx_ext + COUNT_W'(1));
                        state_in = S_REMOVE;
                     end
                  end
                  CMD_READ: begin
                     if (idx_ext < fill_ext) begin
                        rd_addr  = AW'(req_index);
                        state_in = S_READ;
                     end else begin
                        status_in = ST_RANGE;
                        done      = 1'b1;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_INSERT: begin
            // rd_data_ff holds entry ptr-1; move it up while it is larger
            we = 1'b1;
            wr_addr = ptr_ff;
            if (ptr_ff != '0 && $signed(rd_data_ff) > value_ff) begin
               wr_data = rd_data_ff;
               ptr_in  = ptr_ff - AW'(1);
               rd_addr = ptr_ff - AW'(2);
            end else begin
               wr_data  = value_ff;
               fill_in  = fill_ff + FW'(1);
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_REMOVE: begin
            // rd_data_ff holds entry ptr+1; move it down
            we      = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_data_ff;
            if (ptr_plus2 < PW'(fill_ff)) begin
               ptr_in  = ptr_ff + AW'(1);
               rd_addr = AW'(ptr_plus2);
            end else begin
               fill_in  = fill_ff - FW'(1);
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            data_in  = rd_data_ff;
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      value_ff <= value_in;
      if (done) begin
         rsp_status_ff <= status_in;
         rsp_data_ff   <= data_in;
         rsp_count_ff  <= COUNT_W'(fill_in);
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== verif/sorted_list_table_test.sv =====
// Self-checking testbench for the sorted list table: directed and random streams.
`timescale 1ns / 1ps

module sorted_list_table_test;
   import slt_pkg::*;

   localparam int TABLE_DEPTH = CAPACITY_DEF;
   // command code 3 has no member in cmd_type; it must behave as a no-op
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam int MAX_PRINTED = 40;

   typedef struct {
      int                        seq;
      logic [1:0]                command;
      status_type                status;
      logic signed [VALUE_W-1:0] data;
      logic [COUNT_W-1:0]        count;
   } outcome_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_command;
   logic signed [VALUE_W-1:0] req_value;
   logic [INDEX_W-1:0]        req_index;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic signed [VALUE_W-1:0] rsp_data;
   logic [COUNT_W-1:0]        rsp_count;

   // predictor state: the sorted values and how many are held
   logic signed [VALUE_W-1:0] sorted_vals [TABLE_DEPTH];
   int                        held_count;

   outcome_type pending_results[$];
   int          mismatch_total;
   int          beats_sent;
   int          cmd_tally[4];
   int          status_tally[4];
   int          peak_fill;

   sorted_list_table #(
      .CAPACITY(TABLE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_command(req_command),
      .req_value  (req_value),
      .req_index  (req_index),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("timeout: %0d results still outstanding", pending_results.size());
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_total++;
      if (mismatch_total <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   function automatic outcome_type predict_outcome(input logic [1:0] command,
                                                   input logic signed [VALUE_W-1:0] value,
                                                   input logic [INDEX_W-1:0] index);
      outcome_type res;
      int          pos;
      res.command = command;
      res.status  = ST_OK;
      res.data    = '0;
      case (command)
         CMD_INSERT: begin
            if (held_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // new value goes after any equal entries
               pos = 0;
               while (pos < held_count && sorted_vals[pos] <= value) pos++;
               for (int i = held_count; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
               sorted_vals[pos] = value;
               held_count++;
            end
         end
         CMD_REMOVE: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else if (index >= held_count) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = index; i + 1 < held_count; i++) sorted_vals[i] = sorted_vals[i+1];
               held_count--;
            end
         end
         CMD_READ: begin
            if (index < held_count) begin
               res.data = sorted_vals[index];
            end else begin
               res.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      res.count = held_count[COUNT_W-1:0];
      return res;
   endfunction

   // drive at the falling edge, hold until a rising edge sees busy low
   task automatic send_command(input logic [1:0] command,
                               input logic signed [VALUE_W-1:0] value,
                               input logic [INDEX_W-1:0] index);
      outcome_type res;
      @(negedge clock);
      start       = 1'b1;
      req_command = command;
      req_value   = value;
      req_index   = index;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      res     = predict_outcome(command, value, index);
      res.seq = beats_sent;
      pending_results.push_back(res);
      beats_sent++;
      cmd_tally[command]++;
      status_tally[res.status]++;
      if (held_count > peak_fill) peak_fill = held_count;
   endtask

   task automatic idle_burst(input int cycles);
      @(negedge clock);
      start       = 1'b0;
      req_command = 2'($urandom);
      req_value   = $urandom;
      req_index   = 10'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int small_val;
      case ($urandom_range(7))
         0, 1: begin
            // narrow pool so duplicates are common
            small_val = $urandom_range(8);
            return small_val - 4;
         end
         2: begin
            case ($urandom_range(3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh7FFF_FFFE;
               default: return 32'sh8000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      if ($urandom_range(6) == 0) return 10'($urandom_range(1023));
      return 10'($urandom_range(held_count + 1));
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("beat with nothing pending: status %0d data %0d count %0d",
                                      rsp_status, rsp_data, rsp_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("beat %0d cmd %0d: status %0d, want %0d",
                                         want.seq, want.command, rsp_status, want.status));
            if (rsp_data !== want.data)
               report_mismatch($sformatf("beat %0d cmd %0d: data %0d, want %0d",
                                         want.seq, want.command, rsp_data, want.data));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("beat %0d cmd %0d: count %0d, want %0d",
                                         want.seq, want.command, rsp_count, want.count));
         end
      end
   end

   task automatic test_empty_table();
      send_command(CMD_REMOVE, 32'sd0, 10'd0);
      send_command(CMD_READ, 32'sd0, 10'd0);
      send_command(CMD_READ, 32'sd0, 10'd1023);
      send_command(CMD_NOP, 32'sh7FFF_FFFF, 10'd1023);
   endtask

   task automatic test_extremes_and_order();
      send_command(CMD_INSERT, 32'sh7FFF_FFFF, 10'd0);
      send_command(CMD_INSERT, 32'sh8000_0000, 10'd1023);
      send_command(CMD_INSERT, 32'sd0, 10'd0);
      send_command(CMD_INSERT, -32'sd1, 10'd0);
      send_command(CMD_INSERT, 32'sd0, 10'd0);
      send_command(CMD_READ, 32'sd0, 10'd0);
      send_command(CMD_READ, 32'sd0, 10'd4);
      send_command(CMD_READ, 32'sd0, 10'd5);
      send_command(CMD_REMOVE, 32'sd0, 10'd1023);
      send_command(CMD_REMOVE, 32'sd0, 10'd0);
   endtask

   task automatic test_full_table();
      while (held_count < TABLE_DEPTH) send_command(CMD_INSERT, pick_value(), pick_index());
      send_command(CMD_INSERT, 32'sd1, 10'd0);
      send_command(CMD_READ, 32'sd0, 10'(TABLE_DEPTH - 1));
      send_command(CMD_REMOVE, 32'sd0, 10'd1023);
      send_command(CMD_NOP, 32'sd0, 10'd0);
   endtask

   // tide shifts every few dozen beats so the table swings between empty and full
   task automatic run_random(input int beats, input bit with_gaps);
      int         tide;
      int         r;
      logic [1:0] command;
      tide = 0;
      for (int n = 0; n < beats; n++) begin
         if (n % 48 == 0) tide = $urandom_range(2);
         r = $urandom_range(99);
         case (tide)
            0: command = (r < 65) ? CMD_INSERT : (r < 80) ? CMD_REMOVE :
                         (r < 99) ? CMD_READ : CMD_NOP;
            1: command = (r < 20) ? CMD_INSERT : (r < 75) ? CMD_REMOVE :
                         (r < 99) ? CMD_READ : CMD_NOP;
            default:
               command = (r < 40) ? CMD_INSERT : (r < 70) ? CMD_REMOVE :
                         (r < 99) ? CMD_READ : CMD_NOP;
         endcase
         if (with_gaps && $urandom_range(7) == 0) idle_burst($urandom_range(19, 1));
         send_command(command, pick_value(), pick_index());
      end
   endtask

   task automatic test_random_mix();
      run_random(1300, 1'b1);
   endtask

   task automatic test_back_to_back();
      run_random(200, 1'b0);
   endtask

   task automatic drain_results();
      int waited;
      @(negedge clock);
      start = 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_command    = CMD_INSERT;
      req_value      = '0;
      req_index      = '0;
      held_count     = 0;
      mismatch_total = 0;
      beats_sent     = 0;
      peak_fill      = 0;
      foreach (cmd_tally[i]) cmd_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_extremes_and_order();
      test_full_table();
      test_random_mix();
      test_back_to_back();
      drain_results();

      $display("covered %0d commands: %0d inserts, %0d removes, %0d reads, %0d no-ops",
               beats_sent, cmd_tally[CMD_INSERT], cmd_tally[CMD_REMOVE], cmd_tally[CMD_READ],
               cmd_tally[CMD_NOP]);
      $display("peak fill %0d of %0d; outcomes: %0d ok, %0d empty, %0d out of range, %0d full",
               peak_fill, TABLE_DEPTH, status_tally[ST_OK], status_tally[ST_EMPTY],
               status_tally[ST_RANGE], status_tally[ST_FULL]);
      if (mismatch_total == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatch_total);
         $display("status: fail");
      end
      $finish;
   end

endmodule
